// ===== hdl/act_pkg.sv =====
// Package for the access control table: sizes, action codes, sequencer states, cell types.
// No dependencies.
package act_pkg;

  localparam int SUBJECT_SLOTS = 128;
  localparam int RIGHT_SLOTS   = 16;
  localparam int KEY_BITS      = 16;
  localparam int ID_BITS       = 16;
  localparam int ACTION_BITS   = 3;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_ADD    = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_GRANT  = 3'd2,
    ACT_REVOKE = 3'd3,
    ACT_CHECK  = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_APPLY,
    ST_REPORT
  } state_t;

  // Command broadcast from the sequencer to every cell
  typedef struct packed {
    logic add;    // append at the cell marked tail
    logic remove; // the first match and everything after it shift up
    logic grant;  // append right to the first match
    logic revoke; // drop first occurrence of right in the first match
    logic match;  // register the compare results
  } cell_cmd_t;

endpackage

// ===== hdl/act_cell.sv =====
// One subject slot: key, right count and a small right list, with compare logic.
// Depends on act_pkg.
module act_cell #(
  parameter int KEY_BITS    = act_pkg::KEY_BITS,
  parameter int RIGHT_SLOTS = act_pkg::RIGHT_SLOTS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  act_pkg::cell_cmd_t       cmd,
  input  logic [KEY_BITS-1:0]      subj,
  input  logic [KEY_BITS-1:0]      right,
  input  logic                     valid_in,   // this slot holds a subject
  input  logic                     is_tail,    // first free slot
  input  logic                     prior_hit,  // an earlier valid cell matched
  input  logic                     shift,      // take the next cell's contents
  input  logic [KEY_BITS-1:0]      nb_key,
  input  logic [$clog2(RIGHT_SLOTS+1)-1:0] nb_cnt,
  input  logic [RIGHT_SLOTS*KEY_BITS-1:0]  nb_rights,
  output logic                     hit,        // registered: valid and key equal
  output logic                     has_right,  // registered: holds right
  output logic [KEY_BITS-1:0]      key_o,
  output logic [$clog2(RIGHT_SLOTS+1)-1:0] cnt_o,
  output logic [RIGHT_SLOTS*KEY_BITS-1:0]  rights_o
);
  localparam int CW = $clog2(RIGHT_SLOTS+1);
  localparam int IW = (RIGHT_SLOTS > 1) ? $clog2(RIGHT_SLOTS) : 1;

  logic [KEY_BITS-1:0]   key_r;
  logic [CW-1:0]         cnt_r;
  logic [KEY_BITS-1:0]   rk_r [RIGHT_SLOTS];
  logic                  hit_r, has_r;
  logic [RIGHT_SLOTS-1:0] eq, after_first;
  logic                  sel;

  // Per-right compare and prefix of first occurrence
  always_comb begin
    for (int j = 0; j < RIGHT_SLOTS; j++) begin
      eq[j] = (rk_r[j] == right) && (CW'(j) < cnt_r);
    end
    after_first[0] = eq[0];
    for (int j = 1; j < RIGHT_SLOTS; j++) begin
      after_first[j] = after_first[j-1] | eq[j];
    end
  end

  assign sel = hit_r && !prior_hit;

  // Match registers, reset clears control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
      has_r <= 1'b0;
    end else if (cmd.match) begin
      hit_r <= valid_in && (key_r == subj);
      has_r <= |eq;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (cmd.add && is_tail) begin
      key_r <= subj;
      cnt_r <= '0;
    end else if (cmd.remove && shift) begin
      key_r <= nb_key;
      cnt_r <= nb_cnt;
      for (int j = 0; j < RIGHT_SLOTS; j++) begin
        rk_r[j] <= nb_rights[j*KEY_BITS +: KEY_BITS];
      end
    end else if (cmd.grant && sel && cnt_r < CW'(RIGHT_SLOTS)) begin
      rk_r[cnt_r[IW-1:0]] <= right;
      cnt_r <= cnt_r + CW'(1);
    end else if (cmd.revoke && sel && has_r) begin
      for (int j = 0; j + 1 < RIGHT_SLOTS; j++) begin
        if (after_first[j]) rk_r[j] <= rk_r[j+1];
      end
      cnt_r <= cnt_r - CW'(1);
    end
  end

  assign hit       = hit_r;
  assign has_right = has_r;
  assign key_o     = key_r;
  assign cnt_o     = cnt_r;
  always_comb begin
    for (int j = 0; j < RIGHT_SLOTS; j++) begin
      rights_o[j*KEY_BITS +: KEY_BITS] = rk_r[j];
    end
  end
endmodule

// ===== hdl/access_control_table_top.sv =====
// Top level of the access control table: sequencer plus a chain of subject cells.
// Depends on act_pkg and act_cell.
//
// Channel   Direction  Ports                                   Handshake
// input     in         in_action, in_subject_id, in_right_id   start & !busy
// result    out        out_allowed                             out_valid, one cycle
//
// Each request passes through four steps: accept, compare in every cell, apply, report.
// The compare results are registered in every cell before the first-match chain uses them.
// busy is high from the accept until the sequencer returns to idle.
// rst_n clears the count and sequencer; cell contents are not cleared.
// The receiver cannot stall; out_valid is a single-cycle strobe.
module access_control_table_top #(
  parameter int SUBJECT_SLOTS = act_pkg::SUBJECT_SLOTS,
  parameter int RIGHT_SLOTS   = act_pkg::RIGHT_SLOTS,
  parameter int KEY_BITS      = act_pkg::KEY_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [act_pkg::ACTION_BITS-1:0] in_action,
  input  logic [act_pkg::ID_BITS-1:0]    in_subject_id,
  input  logic [act_pkg::ID_BITS-1:0]    in_right_id,
  output logic                           out_valid,
  output logic                           out_allowed
);
  localparam int CW  = $clog2(RIGHT_SLOTS+1);
  localparam int SCW = $clog2(SUBJECT_SLOTS+1);
  localparam int KB  = (KEY_BITS < act_pkg::ID_BITS) ? KEY_BITS : act_pkg::ID_BITS;

  act_pkg::state_t state_r, state_nxt;
  logic [act_pkg::ACTION_BITS-1:0] act_r;
  logic [KEY_BITS-1:0] subj_r, right_r;
  logic [SCW-1:0]      count_r, count_nxt;
  logic                valid_nxt, allowed_nxt;
  act_pkg::cell_cmd_t  cmd;

  logic [SUBJECT_SLOTS-1:0] hit, has, prior;
  logic [KEY_BITS-1:0] key_w [SUBJECT_SLOTS+1];
  logic [CW-1:0]       cnt_w [SUBJECT_SLOTS+1];
  logic [RIGHT_SLOTS*KEY_BITS-1:0] rk_w [SUBJECT_SLOTS+1];

  assign key_w[SUBJECT_SLOTS] = '0;
  assign cnt_w[SUBJECT_SLOTS] = '0;
  assign rk_w[SUBJECT_SLOTS]  = '0;

  // Prefix of earlier hits along the chain
  always_comb begin
    prior[0] = 1'b0;
    for (int i = 1; i < SUBJECT_SLOTS; i++) prior[i] = prior[i-1] | hit[i-1];
  end

  // Cell chain
  for (genvar i = 0; i < SUBJECT_SLOTS; i++) begin : g_cell
    act_cell #(.KEY_BITS(KEY_BITS), .RIGHT_SLOTS(RIGHT_SLOTS)) u_cell (
      .clk, .rst_n, .cmd,
      .subj(subj_r), .right(right_r),
      .valid_in(SCW'(i) < count_r),
      .is_tail(SCW'(i) == count_r),
      .prior_hit(prior[i]),
      .shift(prior[i] | hit[i]),
      .nb_key(key_w[i+1]), .nb_cnt(cnt_w[i+1]), .nb_rights(rk_w[i+1]),
      .hit(hit[i]), .has_right(has[i]),
      .key_o(key_w[i]), .cnt_o(cnt_w[i]), .rights_o(rk_w[i])
    );
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= act_pkg::ST_IDLE;
      count_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      out_valid <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_allowed <= allowed_nxt;
    if (start && !busy) begin
      act_r   <= in_action;
      subj_r  <= KEY_BITS'(in_subject_id[KB-1:0]);
      right_r <= KEY_BITS'(in_right_id[KB-1:0]);
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    valid_nxt   = 1'b0;
    allowed_nxt = out_allowed;
    cmd         = '0;
    busy        = 1'b1;
    case (state_r)
      act_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) state_nxt = act_pkg::ST_MATCH;
      end
      act_pkg::ST_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = act_pkg::ST_APPLY;
      end
      act_pkg::ST_APPLY: begin
        state_nxt = act_pkg::ST_REPORT;
        case (act_r)
          act_pkg::ACT_ADD: begin
            if (count_r < SCW'(SUBJECT_SLOTS)) begin
              cmd.add   = 1'b1;
              count_nxt = count_r + SCW'(1);
            end
          end
          act_pkg::ACT_REMOVE: begin
            if (|hit) begin
              cmd.remove = 1'b1;
              count_nxt  = count_r - SCW'(1);
            end
          end
          act_pkg::ACT_GRANT:  cmd.grant  = 1'b1;
          act_pkg::ACT_REVOKE: cmd.revoke = 1'b1;
          act_pkg::ACT_CHECK: begin
            valid_nxt   = 1'b1;
            allowed_nxt = |(hit & ~prior & has);
          end
          default: ;
        endcase
      end
      act_pkg::ST_REPORT: state_nxt = act_pkg::ST_IDLE;
      default: state_nxt = act_pkg::ST_IDLE;
    endcase
  end
endmodule

// ===== hdl/act_checker.sv =====
// Port-level checker for the access control table, bound to the top level.
// Depends on act_pkg and the access_control_table_top ports.
module act_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic [act_pkg::ACTION_BITS-1:0] in_action,
  input logic                            out_valid
);
  // Accept makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("not busy after accept");
  // Strobe lasts one cycle
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe too long");
  // A check accepted in idle gives a result strobe once the sequencer reaches the report state
  a_check: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_action == act_pkg::ACT_CHECK |-> ##3 out_valid)
    else $error("check lost");
  // No result while the sequencer is idle
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");
endmodule

bind access_control_table_top act_checker u_act_checker (
  .clk, .rst_n, .start, .busy, .in_action, .out_valid
);
